// ----- sv/clnws_pkg.sv -----
// Package for the character LCD nibble write sequencer: types, codes, microcode table.
`timescale 1ns / 1ps
`default_nettype none
package clnws_pkg;

  localparam int RegW    = 10;
  localparam int HoldW   = 16;
  localparam int ExtraW  = 16;
  localparam int CfgIdxW = 3;
  localparam int StepW   = 3;

  localparam logic [HoldW-1:0] HoldMax = '1;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_INSTR  = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_NIBBLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE_SETUP   = 3'd0,
    REG_ENABLE_HIGH    = 3'd1,
    REG_ENABLE_RECOVER = 3'd2,
    REG_SELECT_SETUP   = 3'd3,
    REG_DATA_SETTLE    = 3'd4
  } reg_idx_t;

  // Microcode field encodings
  typedef enum logic {
    SEL_ONE,
    SEL_WRITE
  } sel_src_t;

  typedef enum logic [1:0] {
    NIB_SHOWN,
    NIB_HIGH,
    NIB_LOW
  } nib_src_t;

  typedef enum logic [1:0] {
    HOLD_SEL_SETUP,
    HOLD_EN_SETUP,
    HOLD_EN_HIGH,
    HOLD_EN_RECOVER
  } hold_src_t;

  typedef struct packed {
    sel_src_t  sel_src;
    logic      enable;
    nib_src_t  nib_src;
    hold_src_t hold_src;
    logic      end_if_single;
    logic      end_always;
  } ctl_t;

  localparam logic [StepW-1:0] EntryData  = 3'd0;
  localparam logic [StepW-1:0] EntryInstr = 3'd1;

  // Microprogram: select setup, then two nibbles of setup / pulse / recover
  function automatic ctl_t ucode_rom(input logic [StepW-1:0] step);
    ctl_t c;
    c = '{SEL_WRITE, 1'b0, NIB_SHOWN, HOLD_EN_SETUP, 1'b0, 1'b1};
    case (step)
      3'd0: c = '{SEL_ONE,   1'b0, NIB_SHOWN, HOLD_SEL_SETUP,  1'b0, 1'b0};
      3'd1: c = '{SEL_WRITE, 1'b0, NIB_HIGH,  HOLD_EN_SETUP,   1'b0, 1'b0};
      3'd2: c = '{SEL_WRITE, 1'b1, NIB_HIGH,  HOLD_EN_HIGH,    1'b0, 1'b0};
      3'd3: c = '{SEL_WRITE, 1'b0, NIB_HIGH,  HOLD_EN_RECOVER, 1'b1, 1'b0};
      3'd4: c = '{SEL_WRITE, 1'b0, NIB_LOW,   HOLD_EN_SETUP,   1'b0, 1'b0};
      3'd5: c = '{SEL_WRITE, 1'b1, NIB_LOW,   HOLD_EN_HIGH,    1'b0, 1'b0};
      3'd6: c = '{SEL_WRITE, 1'b0, NIB_LOW,   HOLD_EN_RECOVER, 1'b0, 1'b1};
      default: c = '{SEL_WRITE, 1'b0, NIB_SHOWN, HOLD_EN_SETUP, 1'b0, 1'b1};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/clnws_if.sv -----
// Channel interfaces for the LCD sequencer: write input, pin step output, configuration.
`timescale 1ns / 1ps
`default_nettype none
interface clnws_in_if import clnws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [7:0]        value;
  logic [ExtraW-1:0] extra_wait_us;
  modport source (output valid, action, value, extra_wait_us, input ready);
  modport sink   (input valid, action, value, extra_wait_us, output ready);
endinterface

interface clnws_out_if import clnws_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             select_level;
  logic             enable_level;
  logic [3:0]       nibble_lines;
  logic [HoldW-1:0] hold_us;
  logic             last_step;
  modport source (output valid, select_level, enable_level, nibble_lines, hold_us,
                  last_step, input ready);
  modport sink   (input valid, select_level, enable_level, nibble_lines, hold_us,
                  last_step, output ready);
endinterface

interface clnws_cfg_if import clnws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [RegW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/char_lcd_nibble_write_sequencer.sv -----
// Top level of the character LCD 4-bit write sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Turns each write transaction into timed pin steps for an HD44780-style LCD in
// 4-bit mode. An instruction byte gives 6 steps, a data byte 7 (a select setup
// step first) and a single high nibble 3; action code 3 is accepted and dropped.
// A write is accepted and then gives one step per cycle while the output is
// taken at once (a stalled output holds the steps back); ready rises again
// as the last step is loaded into the output register.
// The step counter walks a 7-word microcode table; each word
// picks select, enable, nibble and hold source, and flags where a write ends.
// The last step's hold is enable_recover_us plus extra_wait_us (plus
// data_settle_us on data writes), saturated at 65535. Config writes are always
// taken (cfg ready is tied high); indexes past the register list are ignored.
module char_lcd_nibble_write_sequencer
  import clnws_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  clnws_in_if.sink          in_ch,
  clnws_out_if.source       out_ch,
  clnws_cfg_if.sink         cfg_ch
);

  // Configuration registers
  logic [RegW-1:0] en_setup_r, en_high_r, en_recover_r, sel_setup_r, settle_r;

  // Per-write context, captured at accept
  logic             busy_r, busy_nxt;
  logic [StepW-1:0] pc_r, pc_nxt;
  logic             data_wr_r;
  logic             single_r;
  logic [3:0]       hi_r, lo_r;
  logic [ExtraW:0]  tail_r;          // extra wait plus settle, 17 bits
  logic [3:0]       shown_r, shown_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic             o_sel_r, o_en_r, o_last_r;
  logic [3:0]       o_nib_r;
  logic [HoldW-1:0] o_hold_r;

  ctl_t             ctl;
  logic             in_fire, step_fire, step_end;
  logic             s_sel;
  logic [3:0]       s_nib;
  logic [HoldW-1:0] s_hold;
  logic [ExtraW+1:0] last_sum;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign step_fire    = busy_r && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.select_level = o_sel_r;
  assign out_ch.enable_level = o_en_r;
  assign out_ch.nibble_lines = o_nib_r;
  assign out_ch.hold_us      = o_hold_r;
  assign out_ch.last_step    = o_last_r;

  // Config register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_setup_r   <= RegW'(10);
      en_high_r    <= RegW'(10);
      en_recover_r <= RegW'(100);
      sel_setup_r  <= RegW'(1);
      settle_r     <= RegW'(50);
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_ENABLE_SETUP:   en_setup_r   <= cfg_ch.data;
        REG_ENABLE_HIGH:    en_high_r    <= cfg_ch.data;
        REG_ENABLE_RECOVER: en_recover_r <= cfg_ch.data;
        REG_SELECT_SETUP:   sel_setup_r  <= cfg_ch.data;
        REG_DATA_SETTLE:    settle_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Datapath driven by the current control word
  always_comb begin
    ctl      = ucode_rom(pc_r);
    step_end = ctl.end_always || (ctl.end_if_single && single_r);
    last_sum = (ExtraW+2)'(en_recover_r) + (ExtraW+2)'(tail_r);

    case (ctl.sel_src)
      SEL_ONE:   s_sel = 1'b1;
      SEL_WRITE: s_sel = data_wr_r;
      default:   s_sel = data_wr_r;
    endcase

    case (ctl.nib_src)
      NIB_SHOWN: s_nib = shown_r;
      NIB_HIGH:  s_nib = hi_r;
      NIB_LOW:   s_nib = lo_r;
      default:   s_nib = shown_r;
    endcase

    if (step_end) begin
      // final step: recover plus tail, saturating
      s_hold = (last_sum > (ExtraW+2)'(HoldMax)) ? HoldMax : last_sum[HoldW-1:0];
    end else begin
      case (ctl.hold_src)
        HOLD_SEL_SETUP:  s_hold = HoldW'(sel_setup_r);
        HOLD_EN_SETUP:   s_hold = HoldW'(en_setup_r);
        HOLD_EN_HIGH:    s_hold = HoldW'(en_high_r);
        HOLD_EN_RECOVER: s_hold = HoldW'(en_recover_r);
        default:         s_hold = HoldW'(en_setup_r);
      endcase
    end
  end

  // Sequencer control: step counter, busy flag, output valid, shown nibble
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    shown_nxt     = shown_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    if (step_fire) begin
      out_valid_nxt = 1'b1;
      if (step_end) begin
        busy_nxt  = 1'b0;
        shown_nxt = single_r ? hi_r : lo_r;
      end else begin
        pc_nxt = pc_r + StepW'(1);
      end
    end

    if (in_fire && (action_t'(in_ch.action) != ACT_NONE)) begin
      busy_nxt = 1'b1;
      pc_nxt   = (action_t'(in_ch.action) == ACT_DATA) ? EntryData : EntryInstr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      shown_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      shown_r     <= shown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Write context capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_wr_r <= (action_t'(in_ch.action) == ACT_DATA);
      single_r  <= (action_t'(in_ch.action) == ACT_NIBBLE);
      hi_r      <= in_ch.value[7:4];
      lo_r      <= in_ch.value[3:0];
      tail_r    <= (ExtraW+1)'(in_ch.extra_wait_us) +
                   ((action_t'(in_ch.action) == ACT_DATA) ? (ExtraW+1)'(settle_r)
                                                          : '0);
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (step_fire) begin
      o_sel_r  <= s_sel;
      o_en_r   <= ctl.enable;
      o_nib_r  <= s_nib;
      o_hold_r <= s_hold;
      o_last_r <= step_end;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the character LCD 4-bit write sequencer.
`timescale 1ns / 1ps
module tb_top;
  import clnws_pkg::*;

  localparam int IdleLimit     = 4000; // cycles with no transaction at all before giving up
  localparam int SettleCycles  = 16;   // quiet time that also covers a dropped write in flight
  localparam int Phases        = 6;    // register settings after the directed part
  localparam int ItemsPerPhase = 54;   // writes that make pin steps, per setting
  localparam int MaxReports    = 10;

  // One pin state on the LCD bus, as the block reports it
  typedef struct packed {
    logic             sel;
    logic             en;
    logic [3:0]       nib;
    logic [HoldW-1:0] hold;
    logic             last;
  } pin_step_t;

  // Directed row; closing_hold is typed in only where typed is set
  typedef struct {
    action_t           act;
    logic [7:0]        val;
    logic [ExtraW-1:0] extra;
    bit                typed;
    logic [HoldW-1:0]  closing_hold;
  } write_row_t;

  logic clk;
  logic rst_n;

  clnws_in_if  in_ch ();
  clnws_out_if out_ch ();
  clnws_cfg_if cfg_ch ();

  char_lcd_nibble_write_sequencer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Pin steps still owed by the block, oldest first
  pin_step_t steps_due[$];

  // Shadow copy of the timing registers and of what the bus last showed
  logic [RegW-1:0] en_setup_us;
  logic [RegW-1:0] en_high_us;
  logic [RegW-1:0] en_recover_us;
  logic [RegW-1:0] sel_setup_us;
  logic [RegW-1:0] settle_us;
  logic [3:0]      lcd_nibble;
  logic            lcd_select;

  int fail_cnt    = 0;
  int idle_cycles = 0;
  int wait_left   = 0;  // receiver stall cycles left before the next pin step
  bit tight       = 0;  // set: neither side inserts idle cycles

  // Directed writes, all under reset timings (setup 10, high 10, recover 100,
  // select setup 1, settle 50)
  write_row_t script [17] = '{
    // plain closing holds: recover, plus settle on data, plus the extra wait
    '{ACT_INSTR,  8'h00, 16'd0,     1'b1, 16'd100},
    '{ACT_DATA,   8'hFF, 16'd0,     1'b1, 16'd150},
    '{ACT_NIBBLE, 8'h30, 16'd0,     1'b1, 16'd100},
    '{ACT_NIBBLE, 8'h30, 16'd4100,  1'b1, 16'd4200},
    '{ACT_DATA,   8'h48, 16'd1,     1'b1, 16'd151},
    '{ACT_INSTR,  8'h01, 16'd1520,  1'b1, 16'd1620},
    // closing hold just under, at and past the 16-bit ceiling
    '{ACT_INSTR,  8'h28, 16'd65434, 1'b1, 16'd65534},
    '{ACT_INSTR,  8'h28, 16'd65435, 1'b1, 16'd65535},
    '{ACT_DATA,   8'h5A, 16'd65385, 1'b1, 16'd65535},
    '{ACT_DATA,   8'hA5, 16'd65386, 1'b1, 16'd65535},
    '{ACT_INSTR,  8'hFF, 16'd65535, 1'b1, 16'd65535},
    '{ACT_DATA,   8'h00, 16'd65535, 1'b1, 16'd65535},
    // a data write's select setup step must show the nibble left on the bus,
    // and the unused action code must not disturb it
    '{ACT_NIBBLE, 8'hC0, 16'd7,     1'b0, 16'd0},
    '{ACT_NONE,   8'hFF, 16'd65535, 1'b0, 16'd0},
    '{ACT_DATA,   8'h69, 16'd0,     1'b0, 16'd0},
    '{ACT_NONE,   8'h00, 16'd0,     1'b0, 16'd0},
    '{ACT_DATA,   8'h21, 16'd0,     1'b0, 16'd0}
  };

  function automatic pin_step_t pin_step(logic sel, logic en, logic [3:0] nib,
                                         logic [HoldW-1:0] hold, logic last);
    pin_step_t s;
    s.sel  = sel;
    s.en   = en;
    s.nib  = nib;
    s.hold = hold;
    s.last = last;
    return s;
  endfunction

  // Queue the pin steps one write transaction produces. A typed closing hold
  // replaces the computed one.
  function automatic void predict_write(action_t act, logic [7:0] val,
                                        logic [ExtraW-1:0] extra, bit typed,
                                        logic [HoldW-1:0] typed_hold);
    logic             sel;
    logic [3:0]       nib;
    logic [HoldW-1:0] closing;
    int               total;
    int               halves;
    if (act == ACT_NONE) return;
    sel    = (act == ACT_DATA);
    total  = int'(en_recover_us) + int'(extra) + ((act == ACT_DATA) ? int'(settle_us) : 0);
    closing = typed ? typed_hold : ((total > int'(HoldMax)) ? HoldMax : HoldW'(total));
    halves = (act == ACT_NIBBLE) ? 1 : 2;
    // data writes raise select first, still showing the old nibble
    if (act == ACT_DATA)
      steps_due.push_back(pin_step(1'b1, 1'b0, lcd_nibble, HoldW'(sel_setup_us), 1'b0));
    for (int h = 0; h < halves; h++) begin
      nib = (h == 0) ? val[7:4] : val[3:0];
      steps_due.push_back(pin_step(sel, 1'b0, nib, HoldW'(en_setup_us), 1'b0));
      steps_due.push_back(pin_step(sel, 1'b1, nib, HoldW'(en_high_us), 1'b0));
      if (h == halves - 1)
        steps_due.push_back(pin_step(sel, 1'b0, nib, closing, 1'b1));
      else
        steps_due.push_back(pin_step(sel, 1'b0, nib, HoldW'(en_recover_us), 1'b0));
      lcd_nibble = nib;
    end
    lcd_select = sel;
  endfunction

  function automatic void note_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] v);
    case (idx)
      REG_ENABLE_SETUP:   en_setup_us   = v;
      REG_ENABLE_HIGH:    en_high_us    = v;
      REG_ENABLE_RECOVER: en_recover_us = v;
      REG_SELECT_SETUP:   sel_setup_us  = v;
      REG_DATA_SETTLE:    settle_us     = v;
      default: ;  // no such register, write is dropped
    endcase
  endfunction

  // Setting 0 is all zero, setting 1 all ones, the rest random
  function automatic logic [RegW-1:0] reg_value(int phase);
    if (phase == 0) return '0;
    if (phase == 1) return '1;
    return RegW'($urandom);
  endfunction

  function automatic void note_fault(string msg);
    fail_cnt++;
    if (fail_cnt <= MaxReports) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void check_field(string name, logic [HoldW-1:0] want,
                                      logic [HoldW-1:0] got);
    if (got !== want)
      note_fault($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    note_reg(idx, v);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offer one write transaction after a random gap; predict once it is taken.
  // valid stays high across back-to-back transactions.
  task automatic send_write(action_t act, logic [7:0] val, logic [ExtraW-1:0] extra,
                            bit typed, logic [HoldW-1:0] typed_hold);
    int gap;
    gap = tight ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.value         <= val;
    in_ch.extra_wait_us <= extra;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_write(act, val, extra, typed, typed_hold);
  endtask

  // Hold off the sender until every owed pin step has come, then let a
  // possibly dropped write run out before anything else happens
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (steps_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: ready drops for the drawn number of cycles after each pin step
  always @(negedge clk) begin
    if (wait_left > 0) begin
      out_ch.ready <= 1'b0;
      wait_left = wait_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Pin step checker
  always @(posedge clk) begin
    pin_step_t got;
    pin_step_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = pin_step(out_ch.select_level, out_ch.enable_level, out_ch.nibble_lines,
                     out_ch.hold_us, out_ch.last_step);
      wait_left = tight ? 0 : $urandom_range(0, 8);
      if (steps_due.size() == 0) begin
        note_fault($sformatf("pin step with nothing owed: sel %0d en %0d nib %0h hold %0d",
                             got.sel, got.en, got.nib, got.hold));
      end else begin
        want = steps_due.pop_front();
        check_field("select_level", HoldW'(want.sel), HoldW'(got.sel));
        check_field("enable_level", HoldW'(want.en), HoldW'(got.en));
        check_field("nibble_lines", HoldW'(want.nib), HoldW'(got.nib));
        check_field("hold_us", want.hold, got.hold);
        check_field("last_step", HoldW'(want.last), HoldW'(got.last));
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int                counted;
    int                pick;
    action_t           act;
    logic [ExtraW-1:0] extra;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_INSTR;
    in_ch.value         = '0;
    in_ch.extra_wait_us = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_ENABLE_SETUP;
    cfg_ch.data         = '0;
    // reset timings and an idle bus
    en_setup_us   = 10;
    en_high_us    = 10;
    en_recover_us = 100;
    sel_setup_us  = 1;
    settle_us     = 50;
    lcd_nibble    = '0;
    lcd_select    = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      send_write(script[i].act, script[i].val, script[i].extra, script[i].typed,
                 script[i].closing_hold);

    for (int p = 0; p < Phases; p++) begin
      // new timings only on an idle block
      drain();
      write_reg(REG_ENABLE_SETUP, reg_value(p));
      write_reg(REG_ENABLE_HIGH, reg_value(p));
      write_reg(REG_ENABLE_RECOVER, reg_value(p));
      write_reg(REG_SELECT_SETUP, reg_value(p));
      write_reg(REG_DATA_SETTLE, reg_value(p));
      // index past the register list, must change nothing
      write_reg(CfgIdxW'(int'(REG_DATA_SETTLE) + 1 + p % 3), RegW'($urandom));

      counted = 0;
      while (counted < ItemsPerPhase) begin
        if ($urandom_range(0, 15) == 0) tight = !tight;
        if ($urandom_range(0, 29) == 0) drain();
        pick = $urandom_range(0, 15);
        act  = (pick < 5) ? ACT_INSTR : (pick < 11) ? ACT_DATA :
               (pick < 15) ? ACT_NIBBLE : ACT_NONE;
        // extra wait: zero, small, anything, or close to the ceiling
        case ($urandom_range(0, 3))
          0: extra = '0;
          1: extra = ExtraW'($urandom_range(0, 255));
          2: extra = ExtraW'($urandom);
          default: extra = ExtraW'($urandom_range(65000, 65535));
        endcase
        send_write(act, 8'($urandom), extra, 1'b0, '0);
        if (act != ACT_NONE) counted++;
      end
    end

    drain();
    fail_cnt += steps_due.size();
    if (fail_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
